/* design/hsmo_pkg.sv */
// Shared types and constants for the history score move orderer.
// Holds the beat structs, command codes, sizes and the cell address function.
// No dependencies.
package hsmo_pkg;

	localparam int BOARD_SIDE = 11;
	localparam int MAX_MOVES  = 64;

	localparam int CELLS     = BOARD_SIDE * BOARD_SIDE;
	localparam int TAB_DEPTH = 2 * CELLS;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam int LIST_AW   = $clog2(MAX_MOVES);
	localparam int CNT_W     = $clog2(MAX_MOVES + 1);

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_LOAD  = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic       side;
		logic [3:0] row;
		logic [3:0] col;
		logic [4:0] depth;
		logic       last_move;
	} item_t;

	typedef struct packed {
		logic [3:0]  out_row;
		logic [3:0]  out_col;
		logic [31:0] out_score;
		logic        out_last;
	} res_t;

	// One sort list entry: the move and its score, fetched before sorting.
	typedef struct packed {
		logic [3:0]  row;
		logic [3:0]  col;
		logic [31:0] score;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [TAB_AW-1:0] rd_addr;
		logic              wr_en;
		logic [TAB_AW-1:0] wr_addr;
		logic [31:0]       wr_data;
		logic              clr;
		logic              clr_side;
	} tab_req_t;

	function automatic logic on_board(input logic [3:0] row, input logic [3:0] col);
		return (int'(row) < BOARD_SIDE) && (int'(col) < BOARD_SIDE);
	endfunction

	function automatic logic [TAB_AW-1:0] cell_addr(input logic side, input logic [3:0] row,
		input logic [3:0] col);
		return TAB_AW'(int'(side) * CELLS + int'(row) * BOARD_SIDE + int'(col));
	endfunction

endpackage

/* design/hsmo_table.sv */
// Score table of both sides: one synchronous memory plus a valid bit per cell.
// A cell whose valid bit is low reads as zero, so a clear only resets the valid bits of one side.
// Depends on hsmo_pkg.
module hsmo_table (
	input  logic              clk,
	input  logic              arst_n,
	input  hsmo_pkg::tab_req_t req,
	output logic [31:0]       rd_data
);

	logic [31:0] mem [hsmo_pkg::TAB_DEPTH];
	logic [hsmo_pkg::TAB_DEPTH-1:0] vld_q;
	logic [31:0] mem_rd_s1;
	logic        rd_vld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_s1 <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.clr) begin
				for (int k = 0; k < hsmo_pkg::TAB_DEPTH; k++) begin
					if ((k >= hsmo_pkg::CELLS) == req.clr_side) begin
						vld_q[k] <= 1'b0;
					end
				end
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_s1 <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? mem_rd_s1 : 32'd0;

endmodule

/* design/history_score_move_orderer.sv */
// History score move orderer: two history tables and a sort list over them.
// Channels: item/item_valid/item_stall in, res/res_valid/res_stall out; one
// beat per command in, results leave through one output register.
// Clear and load are done on acceptance; add reads the cell, then writes
// it back; a query reads the cell, then loads its result beat from ST_QRESP.
// A last load starts the sort of n listed moves: a score fetch pass per move
// through the list memory and the table memory (ST_FREAD, ST_FTAB, ST_FWR),
// then for each position i a scan (ST_IREAD, ST_ILOAD, then ST_JREAD and
// ST_JCMP per later entry), its move leaving from ST_EMIT as soon as the
// scan ends. The list memory has a single read port.
// While a command is at work item_stall is high. A stalled result beat holds,
// and the sequencer waits in place until the output register is free.
// Reset clears all history scores (by valid bits) and empties the list; the
// block takes an item in the first cycle after reset.
// Depends on hsmo_pkg and hsmo_table.
module history_score_move_orderer (
	input  logic           clk,
	input  logic           arst_n,
	input  hsmo_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_stall,
	output hsmo_pkg::res_t  res,
	output logic           res_valid,
	input  logic           res_stall
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_ADD   = 11'b00000000010,
		ST_QRESP = 11'b00000000100,
		ST_FREAD = 11'b00000001000,
		ST_FTAB  = 11'b00000010000,
		ST_FWR   = 11'b00000100000,
		ST_IREAD = 11'b00001000000,
		ST_ILOAD = 11'b00010000000,
		ST_JREAD = 11'b00100000000,
		ST_JCMP  = 11'b01000000000,
		ST_EMIT  = 11'b10000000000
	} state_t;

	state_t state_q;
	hsmo_pkg::tab_req_t tab_req;
	logic [31:0] tab_rd;

	hsmo_pkg::entry_t lst_mem [hsmo_pkg::MAX_MOVES];
	hsmo_pkg::entry_t lst_rd_s1, lst_wd, cur_q;
	logic lst_we, lst_re;
	logic [hsmo_pkg::LIST_AW-1:0] lst_wa, lst_ra;

	logic [hsmo_pkg::CNT_W-1:0] cnt_q, i_q, j_q;
	logic [hsmo_pkg::TAB_AW-1:0] addr_q;
	logic       onb_q, side_q;
	logic [4:0] depth_q;
	logic [3:0] row_q, col_q;
	logic       res_valid_q;
	hsmo_pkg::res_t res_q;

	logic item_fire, out_free, i_last, j_last, swap, res_load;
	logic [32:0] add_amt;
	logic [33:0] add_sum;
	logic [31:0] add_sat;

	hsmo_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tab_req),
		.rd_data(tab_rd)
	);

	assign item_stall = (state_q != ST_IDLE);
	assign item_fire  = item_valid && !item_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign res_load   = ((state_q == ST_QRESP) || (state_q == ST_EMIT)) && out_free;
	assign i_last     = (i_q + hsmo_pkg::CNT_W'(1)) == cnt_q;
	assign j_last     = (j_q + hsmo_pkg::CNT_W'(1)) == cnt_q;
	assign swap       = cur_q.score < lst_rd_s1.score;

	// A depth of 31 gives 2^32, which always saturates in the 34-bit sum.
	assign add_amt = 33'd2 << depth_q;
	assign add_sum = {2'b00, tab_rd} + {1'b0, add_amt};
	assign add_sat = (add_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : add_sum[31:0];

	always_comb begin
		tab_req = '0;
		lst_we  = 1'b0;
		lst_wa  = i_q[hsmo_pkg::LIST_AW-1:0];
		lst_wd  = cur_q;
		lst_re  = 1'b0;
		lst_ra  = i_q[hsmo_pkg::LIST_AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					case (item.cmd)
						hsmo_pkg::CMD_CLEAR: begin
							tab_req.clr      = 1'b1;
							tab_req.clr_side = item.side;
						end
						hsmo_pkg::CMD_ADD, hsmo_pkg::CMD_QUERY: begin
							tab_req.rd_en   = 1'b1;
							tab_req.rd_addr = hsmo_pkg::cell_addr(item.side, item.row, item.col);
						end
						default: begin
							if (int'(cnt_q) < hsmo_pkg::MAX_MOVES) begin
								lst_we = 1'b1;
								lst_wa = cnt_q[hsmo_pkg::LIST_AW-1:0];
								lst_wd = '{row: item.row, col: item.col, score: 32'd0};
							end
						end
					endcase
				end
			end
			ST_ADD: begin
				tab_req.wr_en   = onb_q;
				tab_req.wr_addr = addr_q;
				tab_req.wr_data = add_sat;
			end
			ST_FREAD, ST_IREAD: begin
				lst_re = 1'b1;
			end
			ST_FTAB: begin
				tab_req.rd_en   = 1'b1;
				tab_req.rd_addr = hsmo_pkg::cell_addr(side_q, lst_rd_s1.row, lst_rd_s1.col);
			end
			ST_FWR: begin
				lst_we = 1'b1;
				lst_wd = '{row: row_q, col: col_q, score: onb_q ? tab_rd : 32'd0};
			end
			ST_JREAD: begin
				lst_re = 1'b1;
				lst_ra = j_q[hsmo_pkg::LIST_AW-1:0];
			end
			ST_JCMP: begin
				// The held entry moves down into slot j when a larger score is found.
				lst_we = swap;
				lst_wa = j_q[hsmo_pkg::LIST_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lst_we) begin
			lst_mem[lst_wa] <= lst_wd;
		end
		if (lst_re) begin
			lst_rd_s1 <= lst_mem[lst_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_fire) begin
						addr_q  <= hsmo_pkg::cell_addr(item.side, item.row, item.col);
						onb_q   <= hsmo_pkg::on_board(item.row, item.col);
						depth_q <= item.depth;
						row_q   <= item.row;
						col_q   <= item.col;
						case (item.cmd)
							hsmo_pkg::CMD_ADD: state_q <= ST_ADD;
							hsmo_pkg::CMD_QUERY: state_q <= ST_QRESP;
							hsmo_pkg::CMD_LOAD: begin
								if (int'(cnt_q) < hsmo_pkg::MAX_MOVES) begin
									cnt_q <= cnt_q + hsmo_pkg::CNT_W'(1);
								end
								if (item.last_move) begin
									side_q  <= item.side;
									i_q     <= '0;
									state_q <= ST_FREAD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD: state_q <= ST_IDLE;
				ST_QRESP: begin
					if (out_free) begin
						res_q       <= '{out_row: row_q, out_col: col_q,
							out_score: onb_q ? tab_rd : 32'd0, out_last: 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				ST_FREAD: state_q <= ST_FTAB;
				ST_FTAB: begin
					row_q   <= lst_rd_s1.row;
					col_q   <= lst_rd_s1.col;
					onb_q   <= hsmo_pkg::on_board(lst_rd_s1.row, lst_rd_s1.col);
					state_q <= ST_FWR;
				end
				ST_FWR: begin
					if (i_last) begin
						i_q     <= '0;
						state_q <= ST_IREAD;
					end else begin
						i_q     <= i_q + hsmo_pkg::CNT_W'(1);
						state_q <= ST_FREAD;
					end
				end
				ST_IREAD: state_q <= ST_ILOAD;
				ST_ILOAD: begin
					cur_q   <= lst_rd_s1;
					j_q     <= i_q + hsmo_pkg::CNT_W'(1);
					state_q <= i_last ? ST_EMIT : ST_JREAD;
				end
				ST_JREAD: state_q <= ST_JCMP;
				ST_JCMP: begin
					if (swap) begin
						cur_q <= lst_rd_s1;
					end
					j_q     <= j_q + hsmo_pkg::CNT_W'(1);
					state_q <= j_last ? ST_EMIT : ST_JREAD;
				end
				ST_EMIT: begin
					if (out_free) begin
						res_q       <= '{out_row: cur_q.row, out_col: cur_q.col,
							out_score: cur_q.score, out_last: i_last};
						if (i_last) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + hsmo_pkg::CNT_W'(1);
							state_q <= ST_IREAD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= hsmo_pkg::MAX_MOVES)
		else $error("list count beyond capacity");

	a_sort_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IREAD || state_q == ST_ILOAD || state_q == ST_EMIT ||
		 state_q == ST_FREAD) |-> (i_q < cnt_q))
		else $error("sort index outside the list");

	a_list_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && i_last) |=> (cnt_q == '0 && state_q == ST_IDLE))
		else $error("list not emptied after final sorted beat");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_QRESP || $past(state_q) == ST_EMIT))
		else $error("result beat raised outside query or emit");

endmodule
